// File: rtl/caf_pkg.sv
// Shared constants, types and helpers of the complementary attitude filter.
`default_nettype none
package caf_pkg;

   localparam int TS_W    = 32;
   localparam int SAMP_W  = 10;
   localparam int FIX_W   = 32;
   localparam int ANG_W   = 16;
   localparam int LPF_W   = 7;
   localparam int CF_W    = 8;
   localparam int ELAP_W  = 25;
   localparam int WGT_W   = 12;
   localparam int ADDR_W  = 3;
   localparam int DATA_W  = 32;

   localparam int MUL_W     = 33;
   localparam int PROD_W    = 2 * MUL_W;
   localparam int NUM_W     = 52;
   localparam int DVS_W     = 20;
   localparam int DIV_BITS  = 4;
   localparam int DIV_STEPS = NUM_W / DIV_BITS;
   localparam int CNT_W     = 4;

   localparam logic [ELAP_W-1:0] TICK_SAT   = 25'd16777216;
   localparam logic [DVS_W-1:0]  DVS_ONE_G  = 20'd25;
   localparam logic [DVS_W-1:0]  DVS_TICK   = 20'd1000000;
   localparam logic [PROD_W-1:0] GATE_Q_LIM = 66'd72 << 32;
   localparam logic [PROD_W-1:0] GATE_RAW_LIM = 66'd71;

   localparam logic [LPF_W-1:0] LPF_RESET = 7'd8;
   localparam logic [CF_W-1:0]  CF_RESET  = 8'd30;

   // register index taken from paddr[2]
   localparam logic REG_LPF = 1'b0;
   localparam logic REG_CF  = 1'b1;

   // operation select shared by multiplier and divider
   localparam logic [1:0] OP_SM  = 2'd0;
   localparam logic [1:0] OP_MAG = 2'd1;
   localparam logic [1:0] OP_INC = 2'd2;
   localparam logic [1:0] OP_BL  = 2'd3;

   typedef struct packed {
      logic       capture;
      logic       mul_en;
      logic       div_start;
      logic [1:0] op;
      logic [1:0] idx;
      logic       sm_raw;
      logic       sm_write;
      logic       t_write;
      logic       gate_write;
      logic       inc_write;
      logic       bl_write;
      logic       load_rsp;
   } caf_cmd_type;

   typedef struct packed {
      logic lpf_zero;
      logic div_done;
      logic div_busy;
      logic used;
      logic rsp_busy;
   } caf_sts_type;

   function automatic logic signed [FIX_W-1:0] sat32(input logic signed [FIX_W:0] v);
      logic signed [FIX_W-1:0] r;
      if (v[FIX_W] != v[FIX_W-1]) begin
         r = v[FIX_W] ? {1'b1, {(FIX_W-1){1'b0}}} : {1'b0, {(FIX_W-1){1'b1}}};
      end else begin
         r = v[FIX_W-1:0];
      end
      return r;
   endfunction

   // integer part of a Q16.16 value, truncated toward zero, low 16 bits
   function automatic logic [ANG_W-1:0] ang_int(input logic signed [FIX_W-1:0] a);
      logic rnd;
      rnd = a[FIX_W-1] && (a[15:0] != 16'h0);
      return a[FIX_W-1:16] + {{(ANG_W-1){1'b0}}, rnd};
   endfunction

endpackage
`default_nettype wire

// File: rtl/caf_if.sv
// Request and response channel interfaces of the complementary attitude filter.
`default_nettype none
interface caf_req_if import caf_pkg::*; ();
   logic                     valid;
   logic                     ready;
   logic [TS_W-1:0]          timestamp;
   logic                     restart;
   logic signed [SAMP_W-1:0] acc_x;
   logic signed [SAMP_W-1:0] acc_y;
   logic signed [SAMP_W-1:0] acc_z;
   logic signed [SAMP_W-1:0] gyro_x;
   logic signed [SAMP_W-1:0] gyro_y;

   modport source (output valid, timestamp, restart, acc_x, acc_y, acc_z, gyro_x, gyro_y,
                   input ready);
   modport sink   (input valid, timestamp, restart, acc_x, acc_y, acc_z, gyro_x, gyro_y,
                   output ready);
endinterface

interface caf_rsp_if import caf_pkg::*; ();
   logic                    valid;
   logic                    ready;
   logic signed [ANG_W-1:0] roll_angle;
   logic signed [ANG_W-1:0] pitch_angle;
   logic                    acc_used;

   modport source (output valid, roll_angle, pitch_angle, acc_used, input ready);
   modport sink   (input valid, roll_angle, pitch_angle, acc_used, output ready);
endinterface
`default_nettype wire

// File: rtl/caf_div.sv
// Iterative signed-by-unsigned divider, four quotient bits a cycle, int32-saturated result.
`default_nettype none
module caf_div import caf_pkg::*; (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     start,
   input  wire logic signed [NUM_W-1:0]  num,
   input  wire logic [DVS_W-1:0]         dvs,
   output logic                          busy,
   output logic                          done,
   output logic signed [FIX_W-1:0]       quotient
);

   logic             busy_ff, busy_in;
   logic             done_ff, done_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic [DVS_W:0]   rem_ff, rem_in;
   logic [NUM_W-1:0] quo_ff, quo_in;
   logic             neg_ff, neg_in;
   logic [DVS_W-1:0] dvs_ff, dvs_in;

   logic [DVS_W:0]   r;
   logic [NUM_W-1:0] q;
   logic             big_pos, big_neg;

   always_comb begin
      r = rem_ff;
      q = quo_ff;
      for (int k = 0; k < DIV_BITS; k++) begin
         r = {r[DVS_W-1:0], q[NUM_W-1]};
         q = {q[NUM_W-2:0], 1'b0};
         if (r >= {1'b0, dvs_ff}) begin
            r = r - {1'b0, dvs_ff};
            q[0] = 1'b1;
         end
      end
   end

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      neg_in  = neg_ff;
      dvs_in  = dvs_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         rem_in  = '0;
         neg_in  = num[NUM_W-1];
         quo_in  = num[NUM_W-1] ? NUM_W'(-num) : num;
         dvs_in  = dvs;
      end else if (busy_ff) begin
         rem_in = r;
         quo_in = q;
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == CNT_W'(DIV_STEPS - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      neg_ff <= neg_in;
      dvs_ff <= dvs_in;
   end

   assign big_pos = quo_ff > NUM_W'(32'h7FFF_FFFF);
   assign big_neg = quo_ff > NUM_W'(32'h8000_0000);

   always_comb begin
      if (neg_ff) begin
         quotient = big_neg ? {1'b1, {(FIX_W-1){1'b0}}} : -quo_ff[FIX_W-1:0];
      end else begin
         quotient = big_pos ? {1'b0, {(FIX_W-1){1'b1}}} : quo_ff[FIX_W-1:0];
      end
   end

   assign busy = busy_ff;
   assign done = done_ff;

endmodule
`default_nettype wire

// File: rtl/caf_dp.sv
// Datapath: filter state, shared multiplier, shared divider and response register.
`default_nettype none
module caf_dp import caf_pkg::*; (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire caf_cmd_type              cmd,
   output caf_sts_type                   sts,
   input  wire logic [LPF_W-1:0]         lpf_factor,
   input  wire logic [CF_W-1:0]          cf_setting,
   input  wire logic [TS_W-1:0]          timestamp,
   input  wire logic                     restart,
   input  wire logic signed [SAMP_W-1:0] acc_x,
   input  wire logic signed [SAMP_W-1:0] acc_y,
   input  wire logic signed [SAMP_W-1:0] acc_z,
   input  wire logic signed [SAMP_W-1:0] gyro_x,
   input  wire logic signed [SAMP_W-1:0] gyro_y,
   input  wire logic                     rsp_ready,
   output logic                          rsp_valid,
   output logic signed [ANG_W-1:0]       roll_angle,
   output logic signed [ANG_W-1:0]       pitch_angle,
   output logic                          acc_used
);

   logic [TS_W-1:0]          prev_tick_ff;
   logic [ELAP_W-1:0]        elapsed_ff, elapsed_in;
   logic signed [SAMP_W-1:0] acc_ff [3];
   logic signed [SAMP_W-1:0] gyro_ff [2];
   logic signed [FIX_W-1:0]  s_ff [3];
   logic signed [FIX_W-1:0]  a_ff [2];
   logic signed [FIX_W-1:0]  t_ff;
   logic signed [PROD_W-1:0] prod_ff;
   logic                     used_ff, used_in;
   logic                     rsp_valid_ff;
   logic [ANG_W-1:0]         roll_ff, pitch_ff;
   logic                     acc_used_ff;

   logic [TS_W-1:0]          d;
   logic [WGT_W-1:0]         w;
   logic signed [MUL_W-1:0]  mul_a, mul_b;
   logic signed [NUM_W-1:0]  div_num, mag_src;
   logic [DVS_W-1:0]         div_dvs;
   logic                     div_busy, div_done;
   logic signed [FIX_W-1:0]  div_q;
   logic signed [FIX_W-1:0]  s_sel, a_sel;
   logic signed [SAMP_W-1:0] acc_sel, gyro_sel;
   logic                     lpf_zero;

   assign lpf_zero = (lpf_factor == '0);
   assign w        = ({4'b0, cf_setting} << 3) + ({4'b0, cf_setting} << 1);
   assign d        = timestamp - prev_tick_ff;
   assign s_sel    = s_ff[cmd.idx];
   assign acc_sel  = acc_ff[cmd.idx];
   assign a_sel    = a_ff[cmd.idx[0]];
   assign gyro_sel = gyro_ff[cmd.idx[0]];

   always_comb begin
      if (restart) elapsed_in = '0;
      else if (d > TS_W'(TICK_SAT)) elapsed_in = TICK_SAT;
      else elapsed_in = d[ELAP_W-1:0];
   end

   always_comb begin
      case (cmd.op)
         OP_SM: begin
            mul_a = {s_sel[FIX_W-1], s_sel};
            mul_b = {{(MUL_W-LPF_W){1'b0}}, LPF_W'(lpf_factor - 1'b1)};
         end
         OP_MAG: begin
            mul_a = {t_ff[FIX_W-1], t_ff};
            mul_b = {t_ff[FIX_W-1], t_ff};
         end
         OP_INC: begin
            mul_a = {{(MUL_W-SAMP_W){gyro_sel[SAMP_W-1]}}, gyro_sel};
            mul_b = {{(MUL_W-ELAP_W){1'b0}}, elapsed_ff};
         end
         default: begin
            mul_a = {a_sel[FIX_W-1], a_sel};
            mul_b = {{(MUL_W-WGT_W){1'b0}}, w};
         end
      endcase
   end

   // raw mode measures the unscaled sample, smoothed mode the filtered value
   assign mag_src = lpf_zero ? {{(NUM_W-SAMP_W){acc_ff[2][SAMP_W-1]}}, acc_ff[2]}
                             : {{(NUM_W-FIX_W){s_ff[2][FIX_W-1]}}, s_ff[2]};

   always_comb begin
      case (cmd.op)
         OP_SM: begin
            div_num = prod_ff[NUM_W-1:0]
                    + {{(NUM_W-SAMP_W-16){acc_sel[SAMP_W-1]}}, acc_sel, 16'h0};
            div_dvs = {{(DVS_W-LPF_W){1'b0}}, lpf_factor};
         end
         OP_MAG: begin
            div_num = {mag_src[NUM_W-2:0], 1'b0};
            div_dvs = DVS_ONE_G;
         end
         OP_INC: begin
            div_num = {prod_ff[NUM_W-17:0], 16'h0};
            div_dvs = DVS_TICK;
         end
         default: begin
            div_num = prod_ff[NUM_W-1:0] - {{(NUM_W-FIX_W){s_sel[FIX_W-1]}}, s_sel};
            div_dvs = {{(DVS_W-WGT_W){1'b0}}, WGT_W'(w + 1'b1)};
         end
      endcase
   end

   caf_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (cmd.div_start),
      .num      (div_num),
      .dvs      (div_dvs),
      .busy     (div_busy),
      .done     (div_done),
      .quotient (div_q)
   );

   always_comb begin
      used_in = used_ff;
      if (cmd.capture) used_in = 1'b0;
      else if (cmd.gate_write) begin
         used_in = lpf_zero ? ($unsigned(prod_ff) <= GATE_RAW_LIM)
                            : ($unsigned(prod_ff) < GATE_Q_LIM);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prev_tick_ff <= '0;
         s_ff[0]      <= '0;
         s_ff[1]      <= '0;
         s_ff[2]      <= '0;
         a_ff[0]      <= '0;
         a_ff[1]      <= '0;
         used_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         used_ff <= used_in;
         if (cmd.capture) prev_tick_ff <= timestamp;
         if (cmd.sm_raw) begin
            s_ff[cmd.idx] <= {{(FIX_W-SAMP_W-16){acc_sel[SAMP_W-1]}}, acc_sel, 16'h0};
         end
         if (cmd.sm_write) s_ff[cmd.idx] <= div_q;
         if (cmd.inc_write) begin
            a_ff[cmd.idx[0]] <= sat32({a_sel[FIX_W-1], a_sel} + {div_q[FIX_W-1], div_q});
         end
         if (cmd.bl_write) a_ff[cmd.idx[0]] <= div_q;
         if (cmd.load_rsp) rsp_valid_ff <= 1'b1;
         else if (rsp_ready) rsp_valid_ff <= 1'b0;
      end
      if (cmd.capture) begin
         elapsed_ff <= elapsed_in;
         acc_ff[0]  <= acc_x;
         acc_ff[1]  <= acc_y;
         acc_ff[2]  <= acc_z;
         gyro_ff[0] <= gyro_x;
         gyro_ff[1] <= gyro_y;
      end
      if (cmd.mul_en) prod_ff <= mul_a * mul_b;
      if (cmd.t_write) t_ff <= div_q;
      if (cmd.load_rsp) begin
         roll_ff     <= ang_int(a_ff[0]);
         pitch_ff    <= ang_int(a_ff[1]);
         acc_used_ff <= used_ff;
      end
   end

   assign sts.lpf_zero = lpf_zero;
   assign sts.div_done = div_done;
   assign sts.div_busy = div_busy;
   assign sts.used     = used_ff;
   assign sts.rsp_busy = rsp_valid_ff && !rsp_ready;

   assign rsp_valid   = rsp_valid_ff;
   assign roll_angle  = roll_ff;
   assign pitch_angle = pitch_ff;
   assign acc_used    = acc_used_ff;

endmodule
`default_nettype wire

// File: rtl/caf_ctrl.sv
// Sequences the datapath: smoothing, gate, integration, blend if the gate passes.
`default_nettype none
module caf_ctrl import caf_pkg::*; (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_ready,
   input  wire caf_sts_type sts,
   output caf_cmd_type      cmd
);

   localparam logic [3:0] ST_IDLE     = 4'd0;
   localparam logic [3:0] ST_SM_MUL   = 4'd1;
   localparam logic [3:0] ST_SM_DIV   = 4'd2;
   localparam logic [3:0] ST_SM_WAIT  = 4'd3;
   localparam logic [3:0] ST_MAG_DIV  = 4'd4;
   localparam logic [3:0] ST_MAG_WAIT = 4'd5;
   localparam logic [3:0] ST_MAG_MUL  = 4'd6;
   localparam logic [3:0] ST_MAG_CHK  = 4'd7;
   localparam logic [3:0] ST_INC_MUL  = 4'd8;
   localparam logic [3:0] ST_INC_DIV  = 4'd9;
   localparam logic [3:0] ST_INC_WAIT = 4'd10;
   localparam logic [3:0] ST_BL_MUL   = 4'd11;
   localparam logic [3:0] ST_BL_DIV   = 4'd12;
   localparam logic [3:0] ST_BL_WAIT  = 4'd13;
   localparam logic [3:0] ST_DONE     = 4'd14;

   logic [3:0] state_ff, state_in;
   logic [1:0] idx_ff, idx_in;

   always_comb begin
      state_in = state_ff;
      idx_in   = idx_ff;
      cmd      = '0;
      cmd.idx  = idx_ff;
      cmd.op   = OP_SM;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.capture = 1'b1;
               idx_in      = '0;
               state_in    = ST_SM_MUL;
            end
         end
         ST_SM_MUL: begin
            if (sts.lpf_zero) begin
               cmd.sm_raw = 1'b1;
               if (idx_ff == 2'd2) begin
                  idx_in   = '0;
                  state_in = ST_MAG_DIV;
               end else begin
                  idx_in = idx_ff + 1'b1;
               end
            end else begin
               cmd.mul_en = 1'b1;
               state_in   = ST_SM_DIV;
            end
         end
         ST_SM_DIV: begin
            cmd.div_start = 1'b1;
            state_in      = ST_SM_WAIT;
         end
         ST_SM_WAIT: begin
            if (sts.div_done) begin
               cmd.sm_write = 1'b1;
               if (idx_ff == 2'd2) begin
                  idx_in   = '0;
                  state_in = ST_MAG_DIV;
               end else begin
                  idx_in   = idx_ff + 1'b1;
                  state_in = ST_SM_MUL;
               end
            end
         end
         ST_MAG_DIV: begin
            cmd.op        = OP_MAG;
            cmd.div_start = 1'b1;
            state_in      = ST_MAG_WAIT;
         end
         ST_MAG_WAIT: begin
            cmd.op = OP_MAG;
            if (sts.div_done) begin
               cmd.t_write = 1'b1;
               state_in    = ST_MAG_MUL;
            end
         end
         ST_MAG_MUL: begin
            cmd.op     = OP_MAG;
            cmd.mul_en = 1'b1;
            state_in   = ST_MAG_CHK;
         end
         ST_MAG_CHK: begin
            cmd.op         = OP_MAG;
            cmd.gate_write = 1'b1;
            idx_in         = '0;
            state_in       = ST_INC_MUL;
         end
         ST_INC_MUL: begin
            cmd.op     = OP_INC;
            cmd.mul_en = 1'b1;
            state_in   = ST_INC_DIV;
         end
         ST_INC_DIV: begin
            cmd.op        = OP_INC;
            cmd.div_start = 1'b1;
            state_in      = ST_INC_WAIT;
         end
         ST_INC_WAIT: begin
            cmd.op = OP_INC;
            if (sts.div_done) begin
               cmd.inc_write = 1'b1;
               if (idx_ff == 2'd1) begin
                  idx_in   = '0;
                  state_in = sts.used ? ST_BL_MUL : ST_DONE;
               end else begin
                  idx_in   = idx_ff + 1'b1;
                  state_in = ST_INC_MUL;
               end
            end
         end
         ST_BL_MUL: begin
            cmd.op     = OP_BL;
            cmd.mul_en = 1'b1;
            state_in   = ST_BL_DIV;
         end
         ST_BL_DIV: begin
            cmd.op        = OP_BL;
            cmd.div_start = 1'b1;
            state_in      = ST_BL_WAIT;
         end
         ST_BL_WAIT: begin
            cmd.op = OP_BL;
            if (sts.div_done) begin
               cmd.bl_write = 1'b1;
               if (idx_ff == 2'd1) begin
                  idx_in   = '0;
                  state_in = ST_DONE;
               end else begin
                  idx_in   = idx_ff + 1'b1;
                  state_in = ST_BL_MUL;
               end
            end
         end
         ST_DONE: begin
            // hold until the response slot is free
            if (!sts.rsp_busy) begin
               cmd.load_rsp = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         idx_ff   <= '0;
      end else begin
         state_ff <= state_in;
         idx_ff   <= idx_in;
      end
   end

   assign req_ready = (state_ff == ST_IDLE);

`ifndef SYNTHESIS
   a_start_free: assert property (@(posedge clock) disable iff (reset)
      cmd.div_start |-> !sts.div_busy) else $error("divider started while busy");
   a_accept_leaves: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> state_ff != ST_IDLE) else $error("request not taken up");
   a_idx_range: assert property (@(posedge clock) disable iff (reset)
      idx_ff != 2'd3) else $error("axis index out of range");
   a_load_free: assert property (@(posedge clock) disable iff (reset)
      cmd.load_rsp |-> !sts.rsp_busy) else $error("response overwritten");
`endif

endmodule
`default_nettype wire

// File: rtl/complementary_attitude_filter.sv
// Top level of the complementary attitude filter: channels, register port and wiring.
//
//   channel   direction  handshake      contents
//   req_if    in         valid/ready    timestamp, restart, acc_x/y/z, gyro_x/y
//   rsp_if    out        valid/ready    roll_angle, pitch_angle, acc_used
//   csr (APB) in         psel/penable   lpf_factor at 0x0, cf_setting at 0x4
//
// One request at a time; each request uses the shared divider, which takes four
// quotient bits per step, for up to eight divides a request.
// Synchronous active-high reset clears the filter state and loads register defaults.
// The finished response waits in its own register; the next request is taken while
// it is still held, and the sequencer stalls only when a second response is ready.
`default_nettype none
module complementary_attitude_filter import caf_pkg::*; (
   input  wire logic              clock,
   input  wire logic              reset,
   caf_req_if.sink                req_if,
   caf_rsp_if.source              rsp_if,
   input  wire logic              psel,
   input  wire logic              penable,
   input  wire logic              pwrite,
   input  wire logic [ADDR_W-1:0] paddr,
   input  wire logic [DATA_W-1:0] pwdata,
   output logic [DATA_W-1:0]      prdata,
   output logic                   pready
);

   logic [LPF_W-1:0] lpf_ff;
   logic [CF_W-1:0]  cf_ff;
   logic             wr_en;
   caf_cmd_type      cmd;
   caf_sts_type      sts;

   assign pready = 1'b1;
   assign wr_en  = psel && penable && pwrite && pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         lpf_ff <= LPF_RESET;
         cf_ff  <= CF_RESET;
      end else if (wr_en) begin
         unique case (paddr[2])
            REG_LPF: lpf_ff <= pwdata[LPF_W-1:0];
            REG_CF:  cf_ff  <= pwdata[CF_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (paddr[2])
         REG_LPF: prdata = {{(DATA_W-LPF_W){1'b0}}, lpf_ff};
         REG_CF:  prdata = {{(DATA_W-CF_W){1'b0}}, cf_ff};
         default: prdata = '0;
      endcase
   end

   caf_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_if.valid),
      .req_ready (req_if.ready),
      .sts       (sts),
      .cmd       (cmd)
   );

   caf_dp u_dp (
      .clock       (clock),
      .reset       (reset),
      .cmd         (cmd),
      .sts         (sts),
      .lpf_factor  (lpf_ff),
      .cf_setting  (cf_ff),
      .timestamp   (req_if.timestamp),
      .restart     (req_if.restart),
      .acc_x       (req_if.acc_x),
      .acc_y       (req_if.acc_y),
      .acc_z       (req_if.acc_z),
      .gyro_x      (req_if.gyro_x),
      .gyro_y      (req_if.gyro_y),
      .rsp_ready   (rsp_if.ready),
      .rsp_valid   (rsp_if.valid),
      .roll_angle  (rsp_if.roll_angle),
      .pitch_angle (rsp_if.pitch_angle),
      .acc_used    (rsp_if.acc_used)
   );

endmodule
`default_nettype wire
